// ===== rtl/bfsa_pkg.sv =====
package bfsa_pkg;

    localparam int HDR_W   = 7;
    localparam int PAGE_W  = 17;
    localparam int WORD_W  = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [HDR_W-1:0]  HDR_RESET   = 7'd32;
    localparam logic [PAGE_W-1:0] PAGE_RESET  = 17'd4096;
    localparam logic [WORD_W-1:0] LIMIT_RESET = 32'd1048576;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_MEMORY = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic              op;
        logic [WORD_W-1:0] request_size;
        logic [WORD_W-1:0] block_address;
    } request_t;

    typedef struct packed {
        logic [WORD_W-1:0] data_address;
        logic [1:0]        status;
    } response_t;

    typedef struct packed {
        logic [WORD_W-1:0] start;
        logic [WORD_W-1:0] size;
        logic              busy;
    } entry_t;

endpackage

// ===== rtl/bfsa_stream_if.sv =====
interface bfsa_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/best_fit_segment_allocator.sv =====
// Best-fit segment allocator.
// req (sink): one word per request; op selects allocate or free, with
//   request_size for allocate and block_address for free.
// rsp (source): one word per request, data_address and status, in order.
// cfg_we/cfg_index/cfg_data: register writes (header, page, limit); the user
//   must write them only while no request is in flight, the block does not enforce it.
// Requests are handled one at a time; req.ready is high only while idle.
// An allocate scans the segment table, then may run the page divider for
//   growth, and shifts entries up to split. A free scans to the segment,
//   walks the free segments after it and shifts the remainder down.
// The segment memory has one read port and one write port (one read, one
//   write per cycle).
// A result waits in the rsp register while the receiver stalls; the next
//   request is accepted meanwhile and completes once the register drains.
// Reset empties the table (count and arena top cleared, no memory sweep)
//   and restores the register defaults.
module best_fit_segment_allocator #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    bfsa_stream_if.sink                    req,
    bfsa_stream_if.source                  rsp,
    input  logic                           cfg_we,
    input  logic [bfsa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bfsa_pkg::WORD_W-1:0]    cfg_data
);

    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SEGMENTS);
    localparam int DVD_W = 33;
    localparam logic [5:0] DIV_STEPS = 6'(DVD_W);

    typedef enum logic [16:0] {
        S_IDLE     = 17'h00001,
        S_SCAN_RD  = 17'h00002,
        S_SCAN_EV  = 17'h00004,
        S_DIV      = 17'h00008,
        S_GROW     = 17'h00010,
        S_SPLIT    = 17'h00020,
        S_UP_RD    = 17'h00040,
        S_UP_WR    = 17'h00080,
        S_REM      = 17'h00100,
        S_BEST     = 17'h00200,
        S_PREV_EV  = 17'h00400,
        S_FWD_RD   = 17'h00800,
        S_FWD_EV   = 17'h01000,
        S_FREE_WR  = 17'h02000,
        S_DN_RD    = 17'h04000,
        S_DN_WR    = 17'h08000,
        S_DONE     = 17'h10000
    } state_t;

    bfsa_pkg::entry_t mem [MAX_SEGMENTS];
    bfsa_pkg::entry_t rd_data;
    logic             mem_we;
    logic [IW-1:0]    mem_wa;
    logic [IW-1:0]    mem_ra;
    bfsa_pkg::entry_t mem_wd;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data <= mem[mem_ra];
    end

    state_t                             state_reg, state_next;
    logic [CW-1:0]                      count_reg, count_next;
    logic [31:0]                        top_reg, top_next;
    logic [bfsa_pkg::HDR_W-1:0]         hdr_reg, hdr_next;
    logic [bfsa_pkg::PAGE_W-1:0]        page_reg, page_next;
    logic [31:0]                        limit_reg, limit_next;
    bfsa_pkg::request_t                 item_reg, item_next;
    logic [CW-1:0]                      idx_reg, idx_next;
    logic [CW-1:0]                      dst_reg, dst_next;
    logic [IW-1:0]                      best_reg, best_next;
    logic [31:0]                        bstart_reg, bstart_next;
    logic [31:0]                        bsize_reg, bsize_next;
    logic                               found_reg, found_next;
    logic [31:0]                        acc_reg, acc_next;
    logic                               pfree_reg, pfree_next;
    logic [31:0]                        psize_reg, psize_next;
    logic [31:0]                        pstart_reg, pstart_next;
    logic [bfsa_pkg::PAGE_W-1:0]        rem_reg, rem_next;
    logic [DVD_W-1:0]                   dvd_reg, dvd_next;
    logic [5:0]                         dcnt_reg, dcnt_next;
    bfsa_pkg::response_t                fin_reg, fin_next;
    bfsa_pkg::response_t                res_reg, res_next;
    logic                               rvalid_reg, rvalid_next;

    logic [bfsa_pkg::PAGE_W-1:0] divisor;
    logic [bfsa_pkg::PAGE_W:0]   trial;
    logic [33:0]                 grow;
    logic [34:0]                 new_top;
    logic [31:0]                 hdr32;

    assign hdr32   = 32'(hdr_reg);
    assign divisor = (page_reg == '0) ? bfsa_pkg::PAGE_W'(1) : page_reg;
    assign trial   = {rem_reg, dvd_reg[DVD_W-1]};
    assign grow    = 34'({1'b0, item_reg.request_size} + {25'd0, hdr_reg, 1'b0})
                     - 34'(rem_reg) + 34'(divisor);
    assign new_top = 35'(top_reg) + 35'(grow);

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = rvalid_reg;
    assign rsp.data  = res_reg;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        top_next    = top_reg;
        hdr_next    = hdr_reg;
        page_next   = page_reg;
        limit_next  = limit_reg;
        item_next   = item_reg;
        idx_next    = idx_reg;
        dst_next    = dst_reg;
        best_next   = best_reg;
        bstart_next = bstart_reg;
        bsize_next  = bsize_reg;
        found_next  = found_reg;
        acc_next    = acc_reg;
        pfree_next  = pfree_reg;
        psize_next  = psize_reg;
        pstart_next = pstart_reg;
        rem_next    = rem_reg;
        dvd_next    = dvd_reg;
        dcnt_next   = dcnt_reg;
        fin_next    = fin_reg;
        res_next    = res_reg;
        rvalid_next = rvalid_reg;
        mem_we      = 1'b0;
        mem_wa      = '0;
        mem_wd      = '0;
        mem_ra      = idx_reg[IW-1:0];

        if (rvalid_reg && rsp.ready)
        begin
            rvalid_next = 1'b0;
        end

        if (cfg_we)
        begin
            case (cfg_index)
                bfsa_pkg::CFG_HEADER: hdr_next   = cfg_data[bfsa_pkg::HDR_W-1:0];
                bfsa_pkg::CFG_PAGE:   page_next  = cfg_data[bfsa_pkg::PAGE_W-1:0];
                bfsa_pkg::CFG_LIMIT:  limit_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    item_next  = req.data;
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    if (item_reg.op == bfsa_pkg::OP_FREE)
                    begin
                        fin_next   = '{data_address: '0, status: bfsa_pkg::STATUS_NOT_FOUND};
                        state_next = S_DONE;
                    end
                    else if (found_reg)
                    begin
                        state_next = S_SPLIT;
                    end
                    else if (count_reg >= MAX_CNT)
                    begin
                        fin_next   = '{data_address: '0, status: bfsa_pkg::STATUS_NO_MEMORY};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        rem_next   = '0;
                        dvd_next   = {1'b0, item_reg.request_size}
                                     + {25'd0, hdr_reg, 1'b0};
                        dcnt_next  = DIV_STEPS;
                        state_next = S_DIV;
                    end
                end
                else
                begin
                    mem_ra     = idx_reg[IW-1:0];
                    state_next = S_SCAN_EV;
                end
            end
            S_SCAN_EV:
            begin
                idx_next   = idx_reg + CW'(1);
                state_next = S_SCAN_RD;
                if (item_reg.op == bfsa_pkg::OP_ALLOC)
                begin
                    if (!rd_data.busy
                        && (rd_data.size == item_reg.request_size
                            || ({1'b0, item_reg.request_size} + 33'(hdr_reg))
                               < {1'b0, rd_data.size})
                        && (!found_reg || rd_data.size < bsize_reg))
                    begin
                        found_next  = 1'b1;
                        best_next   = idx_reg[IW-1:0];
                        bstart_next = rd_data.start;
                        bsize_next  = rd_data.size;
                    end
                end
                else if (rd_data.start + hdr32 == item_reg.block_address)
                begin
                    best_next   = idx_reg[IW-1:0];
                    bstart_next = rd_data.start;
                    acc_next    = rd_data.size;
                    pfree_next  = 1'b0;
                    idx_next    = idx_reg + CW'(1);
                    if (idx_reg == '0)
                    begin
                        state_next = S_FWD_RD;
                    end
                    else
                    begin
                        mem_ra     = IW'(idx_reg - CW'(1));
                        state_next = S_PREV_EV;
                    end
                end
            end
            S_DIV:
            begin
                if (dcnt_reg == '0)
                begin
                    state_next = S_GROW;
                end
                else
                begin
                    if (trial >= {1'b0, divisor})
                    begin
                        rem_next = bfsa_pkg::PAGE_W'(trial - {1'b0, divisor});
                    end
                    else
                    begin
                        rem_next = bfsa_pkg::PAGE_W'(trial);
                    end
                    dvd_next  = {dvd_reg[DVD_W-2:0], 1'b0};
                    dcnt_next = dcnt_reg - 6'd1;
                end
            end
            S_GROW:
            begin
                if (new_top > 35'(limit_reg))
                begin
                    fin_next   = '{data_address: '0, status: bfsa_pkg::STATUS_NO_MEMORY};
                    state_next = S_DONE;
                end
                else
                begin
                    mem_we      = 1'b1;
                    mem_wa      = count_reg[IW-1:0];
                    mem_wd      = '{start: top_reg, size: 32'(grow) - hdr32, busy: 1'b0};
                    best_next   = count_reg[IW-1:0];
                    bstart_next = top_reg;
                    bsize_next  = 32'(grow) - hdr32;
                    count_next  = count_reg + CW'(1);
                    top_next    = 32'(new_top);
                    state_next  = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                if (item_reg.request_size < bsize_reg && count_reg < MAX_CNT)
                begin
                    idx_next = count_reg - CW'(1);
                    if (count_reg - CW'(1) >= CW'(best_reg) + CW'(1))
                    begin
                        state_next = S_UP_RD;
                    end
                    else
                    begin
                        state_next = S_REM;
                    end
                end
                else
                begin
                    state_next = S_BEST;
                end
            end
            S_UP_RD:
            begin
                mem_ra     = idx_reg[IW-1:0];
                state_next = S_UP_WR;
            end
            S_UP_WR:
            begin
                mem_we = 1'b1;
                mem_wa = IW'(idx_reg + CW'(1));
                mem_wd = rd_data;
                if (idx_reg == CW'(best_reg) + CW'(1))
                begin
                    state_next = S_REM;
                end
                else
                begin
                    idx_next   = idx_reg - CW'(1);
                    state_next = S_UP_RD;
                end
            end
            S_REM:
            begin
                mem_we     = 1'b1;
                mem_wa     = IW'(CW'(best_reg) + CW'(1));
                mem_wd     = '{start: bstart_reg + hdr32 + item_reg.request_size,
                               size: bsize_reg - item_reg.request_size - hdr32,
                               busy: 1'b0};
                bsize_next = item_reg.request_size;
                count_next = count_reg + CW'(1);
                state_next = S_BEST;
            end
            S_BEST:
            begin
                mem_we     = 1'b1;
                mem_wa     = best_reg;
                mem_wd     = '{start: bstart_reg, size: bsize_reg, busy: 1'b1};
                fin_next   = '{data_address: bstart_reg + hdr32,
                               status: bfsa_pkg::STATUS_OK};
                state_next = S_DONE;
            end
            S_PREV_EV:
            begin
                pfree_next  = !rd_data.busy;
                psize_next  = rd_data.size;
                pstart_next = rd_data.start;
                state_next  = S_FWD_RD;
            end
            S_FWD_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    state_next = S_FREE_WR;
                end
                else
                begin
                    mem_ra     = idx_reg[IW-1:0];
                    state_next = S_FWD_EV;
                end
            end
            S_FWD_EV:
            begin
                if (!rd_data.busy)
                begin
                    acc_next   = acc_reg + rd_data.size + hdr32;
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_FWD_RD;
                end
                else
                begin
                    state_next = S_FREE_WR;
                end
            end
            S_FREE_WR:
            begin
                mem_we = 1'b1;
                if (pfree_reg)
                begin
                    mem_wa   = IW'(CW'(best_reg) - CW'(1));
                    mem_wd   = '{start: pstart_reg, size: psize_reg + acc_reg + hdr32,
                                 busy: 1'b0};
                    dst_next = CW'(best_reg);
                end
                else
                begin
                    mem_wa   = best_reg;
                    mem_wd   = '{start: bstart_reg, size: acc_reg, busy: 1'b0};
                    dst_next = CW'(best_reg) + CW'(1);
                end
                state_next = S_DN_RD;
            end
            S_DN_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    count_next = dst_reg;
                    fin_next   = '{data_address: '0, status: bfsa_pkg::STATUS_OK};
                    state_next = S_DONE;
                end
                else
                begin
                    mem_ra     = idx_reg[IW-1:0];
                    state_next = S_DN_WR;
                end
            end
            S_DN_WR:
            begin
                mem_we     = 1'b1;
                mem_wa     = dst_reg[IW-1:0];
                mem_wd     = rd_data;
                idx_next   = idx_reg + CW'(1);
                dst_next   = dst_reg + CW'(1);
                state_next = S_DN_RD;
            end
            S_DONE:
            begin
                if (!rvalid_reg || rsp.ready)
                begin
                    res_next    = fin_reg;
                    rvalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            top_reg    <= '0;
            hdr_reg    <= bfsa_pkg::HDR_RESET;
            page_reg   <= bfsa_pkg::PAGE_RESET;
            limit_reg  <= bfsa_pkg::LIMIT_RESET;
            rvalid_reg <= 1'b0;
            found_reg  <= 1'b0;
            dcnt_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            top_reg    <= top_next;
            hdr_reg    <= hdr_next;
            page_reg   <= page_next;
            limit_reg  <= limit_next;
            rvalid_reg <= rvalid_next;
            found_reg  <= found_next;
            dcnt_reg   <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        idx_reg    <= idx_next;
        dst_reg    <= dst_next;
        best_reg   <= best_next;
        bstart_reg <= bstart_next;
        bsize_reg  <= bsize_next;
        acc_reg    <= acc_next;
        pfree_reg  <= pfree_next;
        psize_reg  <= psize_next;
        pstart_reg <= pstart_next;
        rem_reg    <= rem_next;
        dvd_reg    <= dvd_next;
        fin_reg    <= fin_next;
        res_reg    <= res_next;
    end

endmodule
